/* src/uot_pkg.sv */
// Shared types and constants for the oversampled UART transceiver.
// No dependencies; imported by uot_tx, uot_rx and the top level.
`default_nettype none

package uot_pkg;

  // Frame layout: start bit, 8 data bits, optional stop bit on receive.
  localparam int unsigned DATA_BITS = 8;
  localparam logic [3:0] TX_FRAME_BITS = 4'd10;
  localparam logic [3:0] RX_FRAME_BASE = 4'd9;

  // Configuration register indexes.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CHECK_START = 1'd0;
  localparam cfg_idx_t CFG_RX_STOP_BITS = 1'd1;

  typedef struct packed {
    logic level;
    logic busy;
    logic full;
  } tx_status_t;

  typedef struct packed {
    logic                 valid;
    logic [DATA_BITS-1:0] data;
  } rx_result_t;

endpackage

`default_nettype wire

/* src/uot_if.sv */
// Valid/ready channel interfaces for the tick input and the result output.
// Standalone; used by the top level ports.
`default_nettype none

interface uot_in_if;
  logic       valid;
  logic       ready;
  logic       rx_line;
  logic       tx_push;
  logic [7:0] tx_byte;

  modport source (output valid, output rx_line, output tx_push, output tx_byte,
                  input ready);
  modport sink (input valid, input rx_line, input tx_push, input tx_byte,
                output ready);
endinterface

interface uot_out_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       tx_busy;
  logic       tx_queue_full;

  modport source (output valid, output tx_line, output rx_valid, output rx_byte,
                  output tx_busy, output tx_queue_full, input ready);
  modport sink (input valid, input tx_line, input rx_valid, input rx_byte,
                input tx_busy, input tx_queue_full, output ready);
endinterface

`default_nettype wire

/* src/uot_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module uot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* src/uot_tx.sv */
// Transmitter: byte queue (RAM), frame shifter and bit timing.
// Depends on uot_pkg and uot_ram.
`default_nettype none

module uot_tx
  import uot_pkg::*;
#(
  parameter int unsigned OVERSAMPLE     = 16,
  parameter int unsigned TX_QUEUE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       tick,
  input  wire logic       push,
  input  wire logic [7:0] push_byte,
  output tx_status_t      status
);

  localparam int unsigned HW = (TX_QUEUE_DEPTH > 1) ? $clog2(TX_QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TX_QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned PW = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TX_QUEUE_DEPTH);
  localparam logic [HW-1:0] LAST_C = HW'(TX_QUEUE_DEPTH - 1);
  localparam logic [PW-1:0] PHASE_LAST = PW'(OVERSAMPLE - 1);

  logic [HW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [9:0]    shift_r, shift_nxt;
  logic [3:0]    bits_r, bits_nxt;
  logic          active_r, active_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic          level_r, level_nxt;

  logic          we;
  logic [HW-1:0] waddr;
  logic [SW-1:0] wsum;
  logic [7:0]    rdata;
  logic [7:0]    q_data;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;

  uot_ram #(.WIDTH(8), .DEPTH(TX_QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (push_byte),
    .raddr (head_nxt),
    .rdata (rdata)
  );

  // Read is registered; a write landing on the next head is forwarded.
  assign q_data = fwd_r ? fwd_data_r : rdata;

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    shift_nxt  = shift_r;
    bits_nxt   = bits_r;
    active_nxt = active_r;
    phase_nxt  = phase_r;
    level_nxt  = level_r;
    we         = 1'b0;
    wsum       = '0;
    waddr      = '0;
    if (tick) begin
      if (active_r) begin
        if (phase_r == '0) begin
          if (bits_r == '0) begin
            if (count_r == '0) begin
              active_nxt = 1'b0;
            end else begin
              shift_nxt = {1'b1, q_data, 1'b0};
              head_nxt  = (head_r == LAST_C) ? '0 : head_r + 1'b1;
              count_nxt = count_r - 1'b1;
              bits_nxt  = TX_FRAME_BITS;
            end
          end
          if (active_nxt) begin
            level_nxt = shift_nxt[0];
            shift_nxt = shift_nxt >> 1;
            bits_nxt  = bits_nxt - 1'b1;
          end
        end
        phase_nxt = (phase_r == PHASE_LAST) ? '0 : phase_r + 1'b1;
      end
      if (push && (count_nxt < DEPTH_C)) begin
        we        = 1'b1;
        wsum      = SW'(head_nxt) + SW'(count_nxt);
        waddr     = (wsum >= SW'(TX_QUEUE_DEPTH)) ? HW'(wsum - SW'(TX_QUEUE_DEPTH))
                                                  : HW'(wsum);
        count_nxt = count_nxt + 1'b1;
      end
      if (!active_nxt && (count_nxt != '0)) begin
        active_nxt = 1'b1;
        phase_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      shift_r  <= '1;
      bits_r   <= '0;
      active_r <= 1'b0;
      phase_r  <= '0;
      level_r  <= 1'b1;
      fwd_r    <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      shift_r  <= shift_nxt;
      bits_r   <= bits_nxt;
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      level_r  <= level_nxt;
      fwd_r    <= we && (waddr == head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= push_byte;
  end

  assign status.level = level_nxt;
  assign status.busy  = active_nxt;
  assign status.full  = (count_nxt == DEPTH_C);

endmodule

`default_nettype wire

/* src/uot_rx.sv */
// Receiver: start edge detect, mid-bit sampling and framing check.
// Depends on uot_pkg.
`default_nettype none

module uot_rx
  import uot_pkg::*;
#(
  parameter int unsigned OVERSAMPLE = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic tick,
  input  wire logic line,
  input  wire logic check_start,
  input  wire logic stop_bits,
  output rx_result_t result
);

  localparam int unsigned PW = $clog2(OVERSAMPLE + 1);
  localparam logic [PW-1:0] PHASE_FULL = PW'(OVERSAMPLE);
  localparam logic [PW-1:0] PHASE_HALF = PW'(OVERSAMPLE / 2 - 1);

  logic          prev_r, prev_nxt;
  logic          active_r, active_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic [9:0]    shift_r, shift_nxt;
  logic [3:0]    bits_r, bits_nxt;
  logic [3:0]    total;
  logic          ok;

  assign total = RX_FRAME_BASE + {3'b000, stop_bits};

  always_comb begin
    prev_nxt   = prev_r;
    active_nxt = active_r;
    phase_nxt  = phase_r;
    shift_nxt  = shift_r;
    bits_nxt   = bits_r;
    ok         = 1'b0;
    result     = '0;
    if (tick) begin
      if (active_r) begin
        if (phase_r != '0) begin
          phase_nxt = phase_r - 1'b1;
        end
        if (phase_nxt == '0) begin
          phase_nxt = PHASE_FULL;
          if (bits_r != '0) begin
            // Bit position outside the current frame length is dropped.
            if (bits_r <= total) begin
              shift_nxt = shift_r | (10'(line) << (total - bits_r));
            end
            if (check_start && (bits_r == total) && (shift_nxt != '0)) begin
              bits_nxt = '0;
            end else begin
              bits_nxt = bits_r - 1'b1;
            end
          end
          if (bits_nxt == '0) begin
            active_nxt = 1'b0;
            if (stop_bits) begin
              ok = shift_nxt[9];
            end else if (check_start) begin
              ok = !shift_nxt[0];
            end else begin
              ok = 1'b1;
            end
            result.valid = ok;
            result.data  = ok ? shift_nxt[8:1] : '0;
          end
        end
      end else if (prev_r && !line) begin
        active_nxt = 1'b1;
        phase_nxt  = PHASE_HALF;
        shift_nxt  = '0;
        bits_nxt   = total;
      end
      prev_nxt = line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= 1'b1;
      active_r <= 1'b0;
      phase_r  <= '0;
      shift_r  <= '0;
      bits_r   <= '0;
    end else begin
      prev_r   <= prev_nxt;
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      shift_r  <= shift_nxt;
      bits_r   <= bits_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/uart_oversampled_transceiver_unit.sv */
// Oversampled 8N1 UART transceiver, one input transfer per oversample tick.
// Path: an input transfer goes through the input reg and then the result reg.
// Throughput: one tick per cycle unless a held result (out_ch.ready low) stalls it.
// Reset (rst_n, synchronous, active low): tx idle high, queue empty, rx idle,
// check_start_bit = 1, rx_stop_bits = 0. Depends on uot_pkg, uot_if, uot_tx, uot_rx.
`default_nettype none

module uart_oversampled_transceiver_unit
  import uot_pkg::*;
#(
  parameter int unsigned OVERSAMPLE     = 16,
  parameter int unsigned TX_QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  uot_in_if.sink        in_ch,
  uot_out_if.source     out_ch,
  input  wire logic     cfg_we,
  input  wire cfg_idx_t cfg_index,
  input  wire logic     cfg_wdata
);

  // Configuration registers
  logic check_start_r, check_start_nxt;
  logic stop_bits_r, stop_bits_nxt;

  // Input register stage
  logic       in_vld_r, in_vld_nxt;
  logic       rx_line_r;
  logic       tx_push_r;
  logic [7:0] tx_byte_r;

  // Result register stage
  logic       out_vld_r, out_vld_nxt;
  tx_status_t tx_stat_r;
  rx_result_t rx_res_r;

  logic       in_xfer;
  logic       advance;   // result register free to take a new tick
  logic       tick;      // the held tick is processed this cycle
  tx_status_t tx_stat;
  rx_result_t rx_res;

  assign advance      = !out_vld_r || out_ch.ready;
  assign tick         = in_vld_r && advance;
  assign in_ch.ready  = !in_vld_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_comb begin
    check_start_nxt = check_start_r;
    stop_bits_nxt   = stop_bits_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHECK_START:  check_start_nxt = cfg_wdata;
        CFG_RX_STOP_BITS: stop_bits_nxt   = cfg_wdata;
      endcase
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (tick) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = advance ? tick : out_vld_r;
  end

  // Tick processing: each unit updates its state only when tick is high.
  uot_tx #(.OVERSAMPLE(OVERSAMPLE), .TX_QUEUE_DEPTH(TX_QUEUE_DEPTH)) u_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .push      (tx_push_r),
    .push_byte (tx_byte_r),
    .status    (tx_stat)
  );

  uot_rx #(.OVERSAMPLE(OVERSAMPLE)) u_rx (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .line        (rx_line_r),
    .check_start (check_start_r),
    .stop_bits   (stop_bits_r),
    .result      (rx_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_start_r <= 1'b1;
      stop_bits_r   <= 1'b0;
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      check_start_r <= check_start_nxt;
      stop_bits_r   <= stop_bits_nxt;
      in_vld_r      <= in_vld_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rx_line_r <= in_ch.rx_line;
      tx_push_r <= in_ch.tx_push;
      tx_byte_r <= in_ch.tx_byte;
    end
    if (tick) begin
      tx_stat_r <= tx_stat;
      rx_res_r  <= rx_res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.tx_line       = tx_stat_r.level;
  assign out_ch.tx_busy       = tx_stat_r.busy;
  assign out_ch.tx_queue_full = tx_stat_r.full;
  assign out_ch.rx_valid      = rx_res_r.valid;
  assign out_ch.rx_byte       = rx_res_r.data;

`ifndef ASSERT_OFF
  // A full queue always has the transmitter running.
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && tx_stat_r.full |-> tx_stat_r.busy)
    else $error("queue full while transmitter idle");

  // No data leaks out without a good frame.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !rx_res_r.valid |-> rx_res_r.data == '0)
    else $error("rx byte nonzero without rx_valid");

  // A processed tick always shows up in the result register.
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_vld_r)
    else $error("processed tick produced no result");
`endif

endmodule

`default_nettype wire
